// ----- src/aat_pkg.sv -----
package aat_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned ProdW     = 2 * CoordW;
  localparam int unsigned AccW      = ProdW + 2;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned NumRows   = 3;
  localparam int unsigned NumTerms  = 3;
  localparam int unsigned NumRegs   = 6;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned RegW      = 64;
  localparam int unsigned NumStages = 4;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [AccW-1:0]   acc_t;

  localparam coord_t CoordMax = 32'sh7fff_ffff;
  localparam coord_t CoordMin = 32'sh8000_0000;

  typedef enum logic [RegIdxW-1:0] {
    REG_X_COEF_XY      = 3'd0,
    REG_X_COEF_Z_SHIFT = 3'd1,
    REG_Y_COEF_XY      = 3'd2,
    REG_Y_COEF_Z_SHIFT = 3'd3,
    REG_Z_COEF_XY      = 3'd4,
    REG_Z_COEF_Z_SHIFT = 3'd5
  } reg_idx_e;

  // identity transform
  localparam logic [RegW-1:0] CfgReset [NumRegs] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t t;
  } row_coef_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
    logic [NumStages-1:0] vld;
  } pipe_ctl_t;

endpackage

// ----- src/aat_if.sv -----
interface aat_in_if import aat_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t in_min_x;
  coord_t in_min_y;
  coord_t in_min_z;
  coord_t in_max_x;
  coord_t in_max_y;
  coord_t in_max_z;

  modport source (output valid, output in_min_x, output in_min_y, output in_min_z,
                  output in_max_x, output in_max_y, output in_max_z, input ready);
  modport sink (input valid, input in_min_x, input in_min_y, input in_min_z,
                input in_max_x, input in_max_y, input in_max_z, output ready);
endinterface

interface aat_out_if import aat_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_min_x;
  coord_t out_min_y;
  coord_t out_min_z;
  coord_t out_max_x;
  coord_t out_max_y;
  coord_t out_max_z;

  modport source (output valid, output out_min_x, output out_min_y, output out_min_z,
                  output out_max_x, output out_max_y, output out_max_z, input ready);
  modport sink (input valid, input out_min_x, input out_min_y, input out_min_z,
                input out_max_x, input out_max_y, input out_max_z, output ready);
endinterface

interface aat_cfg_if import aat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] reg_index;
  logic [RegW-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- src/aat_cfg.sv -----
module aat_cfg import aat_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  aat_cfg_if.sink                    cfg_i,
  output row_coef_t [NumRows-1:0]    coef_o
);

  logic [RegW-1:0] reg_q [NumRegs];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        reg_q[i] <= CfgReset[i];
      end
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.reg_index))
        REG_X_COEF_XY:      reg_q[REG_X_COEF_XY]      <= cfg_i.wdata;
        REG_X_COEF_Z_SHIFT: reg_q[REG_X_COEF_Z_SHIFT] <= cfg_i.wdata;
        REG_Y_COEF_XY:      reg_q[REG_Y_COEF_XY]      <= cfg_i.wdata;
        REG_Y_COEF_Z_SHIFT: reg_q[REG_Y_COEF_Z_SHIFT] <= cfg_i.wdata;
        REG_Z_COEF_XY:      reg_q[REG_Z_COEF_XY]      <= cfg_i.wdata;
        REG_Z_COEF_Z_SHIFT: reg_q[REG_Z_COEF_Z_SHIFT] <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      coef_o[r].cx = coord_t'(reg_q[2*r][CoordW-1:0]);
      coef_o[r].cy = coord_t'(reg_q[2*r][RegW-1:CoordW]);
      coef_o[r].cz = coord_t'(reg_q[2*r+1][CoordW-1:0]);
      coef_o[r].t  = coord_t'(reg_q[2*r+1][RegW-1:CoordW]);
    end
  end

endmodule

// ----- src/aat_ctrl.sv -----
module aat_ctrl import aat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output pipe_ctl_t ctl_o
);

  logic [NumStages-1:0] vld_q, vld_d, load;

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    load[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
    for (int k = 0; k < NumStages; k++) begin
      if (load[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = vld_q[NumStages-1];
  assign ctl_o.load  = load;
  assign ctl_o.vld   = vld_q;

endmodule

// ----- src/aat_row.sv -----
module aat_row import aat_pkg::*; (
  input  logic      clk_i,
  input  pipe_ctl_t ctl_i,
  input  row_coef_t coef_i,
  input  coord_t    lo_i [NumTerms],
  input  coord_t    hi_i [NumTerms],
  output coord_t    mn_o,
  output coord_t    mx_o
);

  coord_t cf [NumTerms];
  prod_t  plo_q [NumTerms];
  prod_t  phi_q [NumTerms];
  prod_t  tmin_q [NumTerms];
  prod_t  tmax_q [NumTerms];
  acc_t   smin_q, smax_q, smin_d, smax_d, shmin, shmax;
  coord_t mn_q, mx_q, mn_d, mx_d;

  assign cf[0] = coef_i.cx;
  assign cf[1] = coef_i.cy;
  assign cf[2] = coef_i.cz;

  // stage 1: one product per coefficient and box edge
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      for (int i = 0; i < NumTerms; i++) begin
        plo_q[i] <= prod_t'(cf[i]) * prod_t'(lo_i[i]);
        phi_q[i] <= prod_t'(cf[i]) * prod_t'(hi_i[i]);
      end
    end
  end

  // stage 2: each term depends on one axis only, so the extreme corner
  // is found term by term
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[1]) begin
      for (int i = 0; i < NumTerms; i++) begin
        tmin_q[i] <= (plo_q[i] < phi_q[i]) ? plo_q[i] : phi_q[i];
        tmax_q[i] <= (plo_q[i] < phi_q[i]) ? phi_q[i] : plo_q[i];
      end
    end
  end

  // stage 3: exact Q32.32 sum with the translation aligned
  always_comb begin
    smin_d = (acc_t'(coef_i.t) <<< FracBits) + acc_t'(tmin_q[0])
           + acc_t'(tmin_q[1]) + acc_t'(tmin_q[2]);
    smax_d = (acc_t'(coef_i.t) <<< FracBits) + acc_t'(tmax_q[0])
           + acc_t'(tmax_q[1]) + acc_t'(tmax_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[2]) begin
      smin_q <= smin_d;
      smax_q <= smax_d;
    end
  end

  // stage 4: floor shift and saturate, both monotone so min and max survive
  always_comb begin
    shmin = smin_q >>> FracBits;
    shmax = smax_q >>> FracBits;
    if (shmin > acc_t'(CoordMax)) begin
      mn_d = CoordMax;
    end else if (shmin < acc_t'(CoordMin)) begin
      mn_d = CoordMin;
    end else begin
      mn_d = coord_t'(shmin[CoordW-1:0]);
    end
    if (shmax > acc_t'(CoordMax)) begin
      mx_d = CoordMax;
    end else if (shmax < acc_t'(CoordMin)) begin
      mx_d = CoordMin;
    end else begin
      mx_d = coord_t'(shmax[CoordW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[3]) begin
      mn_q <= mn_d;
      mx_q <= mx_d;
    end
  end

  assign mn_o = mn_q;
  assign mx_o = mx_q;

endmodule

// ----- src/aat_bbox_transform.sv -----
// channel   | dir | beat contents
// ----------+-----+--------------------------------------------------------
// in_i      | in  | box min and max corners, signed Q16.16
// out_o     | out | transformed box min and max corners, signed Q16.16
// cfg_i     | in  | register index and 64-bit value, always ready
//
// four register stages: multiply, per-term min/max, sum, shift and saturate;
// one box per cycle while the output is not stalled, every stage fully pipelined.
// reset clears the stage valid bits and loads the identity transform.
// a stall at the output holds each full stage; empty stages keep filling.
module aabb_affine_transform import aat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  aat_in_if.sink    in_i,
  aat_out_if.source out_o,
  aat_cfg_if.sink   cfg_i
);

  pipe_ctl_t                 ctl;
  row_coef_t [NumRows-1:0]   coef;
  coord_t                    lo [NumTerms];
  coord_t                    hi [NumTerms];
  coord_t                    mn [NumRows];
  coord_t                    mx [NumRows];
  box_t                      box_in;
  box_t                      box_q [NumStages];
  logic [NumStages-1:0]      empty_q;
  logic                      empty_in;

  aat_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  aat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .ctl_o       (ctl)
  );

  assign lo[0] = in_i.in_min_x;
  assign lo[1] = in_i.in_min_y;
  assign lo[2] = in_i.in_min_z;
  assign hi[0] = in_i.in_max_x;
  assign hi[1] = in_i.in_max_y;
  assign hi[2] = in_i.in_max_z;

  assign box_in = '{min_x: in_i.in_min_x, min_y: in_i.in_min_y, min_z: in_i.in_min_z,
                    max_x: in_i.in_max_x, max_y: in_i.in_max_y, max_z: in_i.in_max_z};

  assign empty_in = (in_i.in_min_x > in_i.in_max_x) || (in_i.in_min_y > in_i.in_max_y)
                 || (in_i.in_min_z > in_i.in_max_z);

  for (genvar r = 0; r < NumRows; r++) begin : g_row
    aat_row u_row (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .coef_i (coef[r]),
      .lo_i   (lo),
      .hi_i   (hi),
      .mn_o   (mn[r]),
      .mx_o   (mx[r])
    );
  end

  // empty boxes ride alongside and bypass the arithmetic
  always_ff @(posedge clk_i) begin
    if (ctl.load[0]) begin
      box_q[0]   <= box_in;
      empty_q[0] <= empty_in;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ctl.load[k]) begin
        box_q[k]   <= box_q[k-1];
        empty_q[k] <= empty_q[k-1];
      end
    end
  end

  assign out_o.out_min_x = empty_q[NumStages-1] ? box_q[NumStages-1].min_x : mn[0];
  assign out_o.out_min_y = empty_q[NumStages-1] ? box_q[NumStages-1].min_y : mn[1];
  assign out_o.out_min_z = empty_q[NumStages-1] ? box_q[NumStages-1].min_z : mn[2];
  assign out_o.out_max_x = empty_q[NumStages-1] ? box_q[NumStages-1].max_x : mx[0];
  assign out_o.out_max_y = empty_q[NumStages-1] ? box_q[NumStages-1].max_y : mx[1];
  assign out_o.out_max_z = empty_q[NumStages-1] ? box_q[NumStages-1].max_z : mx[2];

  // a transformed non-empty box never comes out inverted
  a_minmax_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !empty_q[NumStages-1] |->
      (mn[0] <= mx[0]) && (mn[1] <= mx[1]) && (mn[2] <= mx[2]))
    else $error("transformed box min exceeds max");

  // a stage only turns valid when the stage before it held a beat
  a_stage1_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ctl.vld[1]) |-> $past(ctl.vld[0]))
    else $error("stage 2 valid without stage 1 beat");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(ctl.vld[NumStages-2]))
    else $error("output valid without a beat in flight");

  // input back-pressure only when the first stage is occupied
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> ctl.vld[0] && out_o.valid && !out_o.ready)
    else $error("input stalled with room in the pipeline");

endmodule
